### rtl/fla_pkg.sv
// ---------------------------------------------------------------------------
// fla_pkg
// shared types, constants and codes of the free list fit allocator
// ---------------------------------------------------------------------------
package fla_pkg;

	localparam int HEADER_BYTES    = 16;
	localparam int CTRL_BYTES      = 32;
	localparam int ARENA_MIN_BYTES = 128;
	localparam int ARENA_MAX_BYTES = 65536;
	localparam int MAX_BLOCKS_DEF  = 64;

	typedef struct packed {
		logic [15:0] start;
		logic [16:0] len;
	} seg_t;

	localparam seg_t RESET_SEG = '{start: 16'(CTRL_BYTES),
		len: 17'(ARENA_MAX_BYTES - CTRL_BYTES - HEADER_BYTES)};

	typedef enum logic [2:0] {
		CH_IDLE,
		CH_KEEP,
		CH_PUT,
		CH_NEXT,
		CH_INSERT,
		CH_HOLD
	} chain_op_t;

	typedef struct packed {
		chain_op_t op;
		logic      init;
		seg_t      val;
	} chain_ctl_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMEM   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic CFG_FIT_MODE    = 1'b0;
	localparam logic CFG_ARENA_BYTES = 1'b1;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

endpackage

### rtl/free_list_fit_allocator.sv
// ---------------------------------------------------------------------------
// free_list_fit_allocator
// first, best and worst fit allocator over an address-ordered free table
// ---------------------------------------------------------------------------
// The free table and the used table are each a ring of MAX_BLOCKS cells that
// turns one entry per cycle. An allocate takes one turn of the free ring to
// choose a block and one turn of both rings to apply the edit; a free adds a
// turn of the used ring to find the block first, and skips the free ring scan
// when the address is unknown. One transaction is in work at a time; a
// finished result waits in the output register while the next transaction is
// accepted. Writing arena_bytes while idle reloads the tables at once.
module free_list_fit_allocator
	import fla_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // req_bytes[16:0], release_addr[32:17]
	input  logic [0:0]  s_tuser,   // func[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // grant_addr[15:0], grant_bytes[32:16]
	output logic [1:0]  m_tuser,   // status[1:0]
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	localparam int CW = $clog2(MAX_BLOCKS);
	localparam int NW = $clog2(MAX_BLOCKS + 1);
	localparam logic [NW-1:0] N_FULL = NW'(MAX_BLOCKS);
	localparam logic [CW-1:0] I_LAST = CW'(MAX_BLOCKS - 1);

	typedef enum logic [2:0] {S_IDLE, S_USCAN, S_FSCAN, S_DECIDE, S_EDIT, S_OUT} state_t;
	typedef enum logic [2:0] {FE_NONE, FE_MOD, FE_DEL, FE_MODDEL, FE_INS} fedit_t;
	typedef enum logic [1:0] {UE_NONE, UE_INS, UE_DEL} uedit_t;

	state_t        state_q;
	logic [CW-1:0] i_q;
	logic          func_q;
	logic [16:0]   req_q;
	logic [15:0]   addr_q;
	logic [1:0]    fit_q;
	logic [NW-1:0] fcount_q, ucount_q;

	logic          ufound_q;
	logic [NW-1:0] u_q;
	seg_t          us_q;

	logic          found_q, done_q;
	logic [16:0]   best_q;
	logic [NW-1:0] k_q;
	seg_t          kseg_q;

	logic          posfound_q, haveprev_q;
	logic [NW-1:0] pos_q;
	seg_t          prev_q, nxt_q;

	fedit_t        fkind_q;
	logic [NW-1:0] fm_q, fd_q;
	seg_t          fval_q;
	uedit_t        ukind_q;
	logic [NW-1:0] up_q;
	seg_t          uval_q;

	logic [1:0]    rs_q;
	logic [15:0]   ra_q;
	logic [16:0]   rb_q;

	logic          m_tvalid_q;
	logic [39:0]   m_tdata_q;
	logic [1:0]    m_tuser_q;

	seg_t          fhead, uhead;
	chain_ctl_t    fctl, uctl;
	logic [NW-1:0] iw;
	logic          f_iv, u_iv, fit, exact;
	logic [16:0]   surplus;
	logic [16:0]   arena_v;

	// decide stage
	fedit_t        d_fkind;
	logic [NW-1:0] d_fm, d_fd;
	seg_t          d_fval;
	uedit_t        d_ukind;
	logic [NW-1:0] d_up;
	seg_t          d_uval;
	logic [1:0]    d_rs;
	logic [15:0]   d_ra;
	logic [16:0]   d_rb;
	logic [16:0]   k_surplus, prev_end, s_end;
	logic          ml, mr;

	assign iw      = NW'(i_q);
	assign f_iv    = iw < fcount_q;
	assign u_iv    = iw < ucount_q;
	assign fit     = f_iv && (fhead.len >= req_q);
	assign exact   = fhead.len == req_q;
	assign surplus = fhead.len - req_q;

	always_comb begin
		if (cfg_data < 17'(ARENA_MIN_BYTES)) begin
			arena_v = 17'(ARENA_MIN_BYTES);
		end else if (cfg_data > 17'(ARENA_MAX_BYTES)) begin
			arena_v = 17'(ARENA_MAX_BYTES);
		end else begin
			arena_v = cfg_data;
		end
	end

	always_comb begin
		k_surplus = kseg_q.len - req_q;
		prev_end  = {1'b0, prev_q.start} + 17'(HEADER_BYTES) + prev_q.len;
		s_end     = {1'b0, us_q.start} + 17'(HEADER_BYTES) + us_q.len;
		ml        = haveprev_q && (prev_end == {1'b0, us_q.start});
		mr        = posfound_q && (s_end == {1'b0, nxt_q.start});
		d_fkind   = FE_NONE;
		d_fm      = '0;
		d_fd      = '0;
		d_fval    = '0;
		d_ukind   = UE_NONE;
		d_up      = '0;
		d_uval    = '0;
		d_rs      = ST_OK;
		d_ra      = '0;
		d_rb      = '0;
		if (func_q == FUNC_ALLOC) begin
			if (ucount_q >= N_FULL) begin
				d_rs = ST_FULL;
			end else if (!found_q) begin
				d_rs = ST_NOMEM;
			end else begin
				d_ukind = UE_INS;
				d_up    = ucount_q;
				d_ra    = kseg_q.start + 16'(HEADER_BYTES);
				d_fm    = k_q;
				d_fd    = k_q;
				if (k_surplus >= 17'(2 * HEADER_BYTES)) begin
					d_fkind = FE_MOD;
					d_fval  = '{start: 16'({1'b0, kseg_q.start} + 17'(HEADER_BYTES) + req_q),
						len: k_surplus - 17'(HEADER_BYTES)};
					d_rb    = req_q;
				end else begin
					d_fkind = FE_DEL;
					d_rb    = kseg_q.len;
				end
				d_uval = '{start: kseg_q.start, len: d_rb};
			end
		end else begin
			if (!ufound_q) begin
				d_rs = ST_UNKNOWN;
			end else begin
				d_rb    = us_q.len;
				d_ukind = UE_DEL;
				d_up    = u_q;
				d_fm    = pos_q - NW'(1);
				d_fd    = pos_q;
				if (ml && mr) begin
					d_fkind = FE_MODDEL;
					d_fval  = '{start: prev_q.start,
						len: prev_q.len + 17'(2 * HEADER_BYTES) + us_q.len + nxt_q.len};
				end else if (ml) begin
					d_fkind = FE_MOD;
					d_fval  = '{start: prev_q.start,
						len: prev_q.len + 17'(HEADER_BYTES) + us_q.len};
				end else if (mr) begin
					d_fkind = FE_MOD;
					d_fm    = pos_q;
					d_fval  = '{start: us_q.start,
						len: nxt_q.len + 17'(HEADER_BYTES) + us_q.len};
				end else if (fcount_q >= N_FULL) begin
					d_rs    = ST_FULL;
					d_rb    = '0;
					d_ukind = UE_NONE;
				end else begin
					d_fkind = FE_INS;
					d_fm    = pos_q;
					d_fval  = us_q;
				end
			end
		end
	end

	always_comb begin
		fctl      = '{op: CH_IDLE, init: 1'b0, val: fval_q};
		uctl      = '{op: CH_IDLE, init: 1'b0, val: uval_q};
		if (state_q == S_IDLE && cfg_we && cfg_index == CFG_ARENA_BYTES) begin
			fctl.init = 1'b1;
			fctl.val  = '{start: 16'(CTRL_BYTES),
				len: arena_v - 17'(CTRL_BYTES + HEADER_BYTES)};
		end
		if (state_q == S_FSCAN) begin
			fctl.op = CH_KEEP;
		end
		if (state_q == S_USCAN) begin
			uctl.op = CH_KEEP;
		end
		if (state_q == S_EDIT) begin
			case (fkind_q)
				FE_MOD:    fctl.op = (iw == fm_q) ? CH_PUT : CH_KEEP;
				FE_DEL:    fctl.op = (iw >= fd_q) ? CH_NEXT : CH_KEEP;
				FE_MODDEL: fctl.op = (iw == fm_q) ? CH_PUT :
					((iw >= fd_q) ? CH_NEXT : CH_KEEP);
				FE_INS:    fctl.op = (iw < fm_q) ? CH_KEEP :
					((iw == fm_q) ? CH_INSERT : CH_HOLD);
				default:   fctl.op = CH_IDLE;
			endcase
			case (ukind_q)
				UE_INS:  uctl.op = (iw < up_q) ? CH_KEEP :
					((iw == up_q) ? CH_INSERT : CH_HOLD);
				UE_DEL:  uctl.op = (iw >= up_q) ? CH_NEXT : CH_KEEP;
				default: uctl.op = CH_IDLE;
			endcase
		end
	end

	fla_chain #(.DEPTH(MAX_BLOCKS), .RST_HEAD(RESET_SEG)) u_free (
		.clk(clk), .arst_n(arst_n), .ctl(fctl), .head(fhead)
	);

	fla_chain #(.DEPTH(MAX_BLOCKS), .RST_HEAD('0)) u_used (
		.clk(clk), .arst_n(arst_n), .ctl(uctl), .head(uhead)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			i_q        <= '0;
			fit_q      <= FIT_FIRST;
			fcount_q   <= NW'(1);
			ucount_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						case (cfg_index)
							CFG_FIT_MODE: fit_q <= cfg_data[1:0];
							CFG_ARENA_BYTES: begin
								fcount_q <= NW'(1);
								ucount_q <= '0;
							end
							default: ;
						endcase
					end
					if (s_tvalid) begin
						func_q     <= s_tuser[0];
						req_q      <= s_tdata[16:0];
						addr_q     <= s_tdata[32:17];
						i_q        <= '0;
						ufound_q   <= 1'b0;
						found_q    <= 1'b0;
						done_q     <= 1'b0;
						best_q     <= '0;
						posfound_q <= 1'b0;
						haveprev_q <= 1'b0;
						pos_q      <= '0;
						state_q    <= (s_tuser[0] == FUNC_FREE) ? S_USCAN : S_FSCAN;
					end
				end
				S_USCAN: begin
					if (u_iv && !ufound_q &&
						(uhead.start + 16'(HEADER_BYTES)) == addr_q) begin
						ufound_q <= 1'b1;
						u_q      <= iw;
						us_q     <= uhead;
					end
					if (i_q == I_LAST) begin
						i_q     <= '0;
						state_q <= (u_iv && !ufound_q &&
							(uhead.start + 16'(HEADER_BYTES)) == addr_q) || ufound_q ?
							S_FSCAN : S_DECIDE;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				S_FSCAN: begin
					if (func_q == FUNC_ALLOC) begin
						case (fit_q)
							FIT_FIRST: begin
								if (fit && !found_q) begin
									found_q <= 1'b1;
									k_q     <= iw;
									kseg_q  <= fhead;
								end
							end
							FIT_BEST: begin
								if (fit && !done_q) begin
									if (exact) begin
										done_q  <= 1'b1;
										found_q <= 1'b1;
										k_q     <= iw;
										kseg_q  <= fhead;
									end else if (!found_q || surplus < best_q) begin
										found_q <= 1'b1;
										k_q     <= iw;
										kseg_q  <= fhead;
										best_q  <= surplus;
									end
								end
							end
							FIT_WORST: begin
								if (fit && (!found_q || fhead.len >= best_q)) begin
									found_q <= 1'b1;
									k_q     <= iw;
									kseg_q  <= fhead;
									best_q  <= fhead.len;
								end
							end
							default: ;
						endcase
					end else if (f_iv && !posfound_q) begin
						if (fhead.start < us_q.start) begin
							prev_q     <= fhead;
							haveprev_q <= 1'b1;
							pos_q      <= iw + NW'(1);
						end else begin
							posfound_q <= 1'b1;
							nxt_q      <= fhead;
							pos_q      <= iw;
						end
					end
					if (i_q == I_LAST) begin
						i_q     <= '0;
						state_q <= S_DECIDE;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				S_DECIDE: begin
					fkind_q <= d_fkind;
					fm_q    <= d_fm;
					fd_q    <= d_fd;
					fval_q  <= d_fval;
					ukind_q <= d_ukind;
					up_q    <= d_up;
					uval_q  <= d_uval;
					rs_q    <= d_rs;
					ra_q    <= d_ra;
					rb_q    <= d_rb;
					if (d_fkind == FE_DEL || d_fkind == FE_MODDEL) begin
						fcount_q <= fcount_q - NW'(1);
					end else if (d_fkind == FE_INS) begin
						fcount_q <= fcount_q + NW'(1);
					end
					if (d_ukind == UE_INS) begin
						ucount_q <= ucount_q + NW'(1);
					end else if (d_ukind == UE_DEL) begin
						ucount_q <= ucount_q - NW'(1);
					end
					i_q     <= '0;
					state_q <= S_EDIT;
				end
				S_EDIT: begin
					if (i_q == I_LAST) begin
						i_q     <= '0;
						state_q <= S_OUT;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= rs_q;
						m_tdata_q  <= {7'd0, rb_q, ra_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_fcount: assert property (@(posedge clk) disable iff (!arst_n)
		fcount_q <= N_FULL)
		else $error("free table count overflow");
	a_ucount: assert property (@(posedge clk) disable iff (!arst_n)
		ucount_q <= N_FULL)
		else $error("used table count overflow");
	a_edit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DECIDE |=> state_q == S_EDIT && i_q == '0)
		else $error("edit turn not aligned");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && (!m_tvalid_q || m_tready)) |=> m_tvalid_q && state_q == S_IDLE)
		else $error("result not issued");

endmodule

### rtl/fla_cell.sv
// ---------------------------------------------------------------------------
// fla_cell
// one table entry of the segment chain, loaded from its neighbour on shift
// ---------------------------------------------------------------------------
module fla_cell
	import fla_pkg::*;
#(
	parameter seg_t RST_VAL = '0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  seg_t d,
	output seg_t q
);

	seg_t q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= RST_VAL;
		end else if (en) begin
			q_q <= d;
		end
	end

	assign q = q_q;

endmodule

### rtl/fla_chain.sv
// ---------------------------------------------------------------------------
// fla_chain
// ring of segment cells; one full turn edits the table in place
// ---------------------------------------------------------------------------
module fla_chain
	import fla_pkg::*;
#(
	parameter int   DEPTH    = MAX_BLOCKS_DEF,
	parameter seg_t RST_HEAD = '0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  chain_ctl_t ctl,
	output seg_t       head
);

	seg_t q [DEPTH];
	seg_t tail;
	seg_t hold_q;
	logic shift;

	assign shift = (ctl.op != CH_IDLE);

	always_comb begin
		case (ctl.op)
			CH_KEEP:   tail = q[0];
			CH_PUT:    tail = ctl.val;
			CH_NEXT:   tail = q[1];
			CH_INSERT: tail = ctl.val;
			CH_HOLD:   tail = hold_q;
			default:   tail = q[0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.op == CH_INSERT || ctl.op == CH_HOLD) begin
			hold_q <= q[0];
		end
	end

	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		seg_t d_j;
		logic en_j;
		if (j == 0) begin : g_head
			assign en_j = shift | ctl.init;
			assign d_j  = ctl.init ? ctl.val : q[1];
			fla_cell #(.RST_VAL(RST_HEAD)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en_j), .d(d_j), .q(q[j])
			);
		end else if (j == DEPTH - 1) begin : g_tail
			assign en_j = shift;
			assign d_j  = tail;
			fla_cell #(.RST_VAL('0)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en_j), .d(d_j), .q(q[j])
			);
		end else begin : g_mid
			assign en_j = shift;
			assign d_j  = q[j+1];
			fla_cell #(.RST_VAL('0)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en_j), .d(d_j), .q(q[j])
			);
		end
	end

	assign head = q[0];

	a_init_excl: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.init |-> ctl.op == CH_IDLE)
		else $error("chain load during a turn");
	a_keep_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == CH_KEEP |=> q[DEPTH-1] == $past(q[0]))
		else $error("head not wrapped to tail");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == CH_IDLE && !ctl.init) |=> $stable(head))
		else $error("head moved while idle");

endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the free list fit allocator
// ---------------------------------------------------------------------------
// Requests go in on the slave stream and results come out on the master stream.
// A predictor keeps its own free and used tables and works out each result.
// A directed table covers the extremes, whole-block grants, an empty free
// table, double free and unknown addresses. Random phases follow, each with
// its own fit mode and arena size, and include runs that fill the used table.
// Both streams idle at random, and the receiver holds off once for a long
// stretch so that the allocator stalls its input.
// ---------------------------------------------------------------------------
module tb;
	import fla_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         NBLK      = MAX_BLOCKS_DEF;
	localparam int         LIMIT     = 1000000;
	localparam logic [1:0] FIT_NONE  = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] addr;
		logic [16:0] bytes;
	} outcome_t;

	typedef struct {
		logic        func;
		int unsigned req;
		int unsigned addr;
		bit          typed;
		outcome_t    res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [16:0] cfg_data;

	int unsigned free_start[NBLK];
	int unsigned free_len[NBLK];
	int unsigned free_cnt;
	int unsigned used_start[NBLK];
	int unsigned used_len[NBLK];
	int unsigned used_cnt;
	logic [1:0]  fit;
	int unsigned arena;

	outcome_t    pending[$];
	int          errors = 0;
	int          cycles = 0;
	bit          quiet;

	free_list_fit_allocator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL free_list_fit_allocator");
			$finish;
		end
	end

	function void tables_init();
		free_start[0] = CTRL_BYTES;
		free_len[0]   = arena - CTRL_BYTES - HEADER_BYTES;
		free_cnt      = 1;
		used_cnt      = 0;
	endfunction

	function int pick_block(int unsigned req);
		int          found;
		int unsigned best;
		found = -1;
		best  = 0;
		for (int i = 0; i < free_cnt; i++) begin
			if (free_len[i] < req)
				continue;
			if (fit == FIT_FIRST)
				return i;
			if (fit == FIT_BEST) begin
				if (free_len[i] == req)
					return i;
				if (found < 0 || free_len[i] - req < best) begin
					found = i;
					best  = free_len[i] - req;
				end
			end else if (fit == FIT_WORST) begin
				if (found < 0 || free_len[i] >= best) begin
					found = i;
					best  = free_len[i];
				end
			end
		end
		return found;
	endfunction

	function outcome_t alloc_outcome(int unsigned req);
		outcome_t    r;
		int          k;
		int unsigned s, len, grant;
		r = '0;
		if (used_cnt >= NBLK) begin
			r.status = ST_FULL;
			return r;
		end
		k = pick_block(req);
		if (k < 0) begin
			r.status = ST_NOMEM;
			return r;
		end
		s   = free_start[k];
		len = free_len[k];
		if (len - req >= 2 * HEADER_BYTES) begin
			grant         = req;
			free_start[k] = s + HEADER_BYTES + req;
			free_len[k]   = len - req - HEADER_BYTES;
		end else begin
			grant = len;
			for (int i = k; i + 1 < free_cnt; i++) begin
				free_start[i] = free_start[i + 1];
				free_len[i]   = free_len[i + 1];
			end
			free_cnt--;
		end
		used_start[used_cnt] = s;
		used_len[used_cnt]   = grant;
		used_cnt++;
		r.status = ST_OK;
		r.addr   = 16'(s + HEADER_BYTES);
		r.bytes  = 17'(grant);
		return r;
	endfunction

	function outcome_t free_outcome(int unsigned addr);
		outcome_t    r;
		int          u;
		int unsigned pos, s, len;
		bit          ml, mr;
		r = '0;
		u = -1;
		for (int i = 0; i < used_cnt; i++)
			if (u < 0 && ((used_start[i] + HEADER_BYTES) & 16'hFFFF) == addr)
				u = i;
		if (u < 0) begin
			r.status = ST_UNKNOWN;
			return r;
		end
		s   = used_start[u];
		len = used_len[u];
		pos = 0;
		while (pos < free_cnt && free_start[pos] < s)
			pos++;
		ml = pos > 0 && free_start[pos - 1] + HEADER_BYTES + free_len[pos - 1] == s;
		mr = pos < free_cnt && s + HEADER_BYTES + len == free_start[pos];
		if (ml && mr) begin
			free_len[pos - 1] += 2 * HEADER_BYTES + len + free_len[pos];
			for (int i = pos; i + 1 < free_cnt; i++) begin
				free_start[i] = free_start[i + 1];
				free_len[i]   = free_len[i + 1];
			end
			free_cnt--;
		end else if (ml) begin
			free_len[pos - 1] += HEADER_BYTES + len;
		end else if (mr) begin
			free_len[pos]  += HEADER_BYTES + len;
			free_start[pos] = s;
		end else begin
			if (free_cnt >= NBLK) begin
				r.status = ST_FULL;
				return r;
			end
			for (int i = free_cnt; i > pos; i--) begin
				free_start[i] = free_start[i - 1];
				free_len[i]   = free_len[i - 1];
			end
			free_start[pos] = s;
			free_len[pos]   = len;
			free_cnt++;
		end
		used_cnt--;
		used_start[u] = used_start[used_cnt];
		used_len[u]   = used_len[used_cnt];
		r.status = ST_OK;
		r.bytes  = 17'(len);
		return r;
	endfunction

	// one request transaction; typed overrides the predicted outcome
	task automatic request(logic func, int unsigned req, int unsigned addr, bit typed = 0,
			outcome_t want = '0);
		outcome_t r;
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {7'd0, addr[15:0], req[16:0]};
		do @(posedge clk); while (!s_tready);
		r = (func == FUNC_ALLOC) ? alloc_outcome(req) : free_outcome(addr);
		pending.push_back(typed ? want : r);
		if (!quiet && $urandom_range(0, 99) < 6) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [0:0] idx, logic [16:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_FIT_MODE) begin
			fit = val[1:0];
		end else begin
			arena = val < ARENA_MIN_BYTES ? ARENA_MIN_BYTES :
				val > ARENA_MAX_BYTES ? ARENA_MAX_BYTES : val;
			tables_init();
		end
	endtask

	// receiver: random stalls, a calm stretch and one long hold-off
	initial begin
		int n;
		m_tready = 1'b0;
		n = 0;
		forever begin
			@(posedge clk);
			n++;
			if (n >= 9000 && n < 10500)
				m_tready <= 1'b0;
			else if (n >= 20000 && n < 30000)
				m_tready <= 1'b1;
			else
				m_tready <= $urandom_range(0, 99) >= 6;
		end
	end

	always @(posedge clk) begin
		outcome_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{status: m_tuser, addr: m_tdata[15:0], bytes: m_tdata[32:16]};
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $realtime, got);
			end else begin
				want = pending.pop_front();
				if (got.status !== want.status) begin
					errors++;
					$display("%0t: status exp %0d got %0d", $realtime, want.status,
						got.status);
				end
				if (got.addr !== want.addr) begin
					errors++;
					$display("%0t: grant_addr exp %0d got %0d", $realtime, want.addr,
						got.addr);
				end
				if (got.bytes !== want.bytes) begin
					errors++;
					$display("%0t: grant_bytes exp %0d got %0d", $realtime, want.bytes,
						got.bytes);
				end
			end
		end
	end

	initial begin
		dir_row_t    rows[19];
		int          modes[7];
		int unsigned sizes[7];
		int          alloc_pct[7];
		int unsigned req, addr;

		rows = '{
			'{FUNC_ALLOC, 0,     0,     1, '{ST_OK, 16'd48, 17'd0}},
			'{FUNC_FREE,  0,     48,    1, '{ST_OK, 16'd0, 17'd0}},
			'{FUNC_ALLOC, 65470, 0,     1, '{ST_OK, 16'd48, 17'd65488}},
			'{FUNC_ALLOC, 0,     0,     1, '{ST_NOMEM, 16'd0, 17'd0}},
			'{FUNC_FREE,  0,     48,    1, '{ST_OK, 16'd0, 17'd65488}},
			'{FUNC_FREE,  0,     48,    1, '{ST_UNKNOWN, 16'd0, 17'd0}},
			'{FUNC_FREE,  0,     0,     1, '{ST_UNKNOWN, 16'd0, 17'd0}},
			'{FUNC_ALLOC, 65536, 0,     1, '{ST_NOMEM, 16'd0, 17'd0}},
			'{FUNC_FREE,  0,     65535, 1, '{ST_UNKNOWN, 16'd0, 17'd0}},
			'{FUNC_ALLOC, 100,   0,     0, '0},
			'{FUNC_ALLOC, 0,     0,     0, '0},
			'{FUNC_ALLOC, 300,   0,     0, '0},
			'{FUNC_ALLOC, 5,     0,     0, '0},
			'{FUNC_FREE,  0,     164,   0, '0},
			'{FUNC_FREE,  0,     48,    0, '0},
			'{FUNC_ALLOC, 50,    0,     0, '0},
			'{FUNC_FREE,  0,     180,   0, '0},
			'{FUNC_ALLOC, 65535, 0,     0, '0},
			'{FUNC_ALLOC, 1,     0,     0, '0}
		};
		modes     = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_NONE, FIT_BEST, FIT_WORST, FIT_FIRST};
		sizes     = '{65536, 1000, 128, 4000, 0, 131071, 0};
		alloc_pct = '{100, 60, 60, 60, 55, 55, 60};
		sizes[6]  = $urandom_range(128, 65536);

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		quiet     = 0;
		fit       = FIT_FIRST;
		arena     = ARENA_MAX_BYTES;
		tables_init();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			request(rows[i].func, rows[i].req, rows[i].addr, rows[i].typed, rows[i].res);
		drain();

		for (int p = 0; p < 7; p++) begin
			cfg_write(CFG_FIT_MODE, 17'(modes[p]));
			cfg_write(CFG_ARENA_BYTES, 17'(sizes[p]));
			quiet = (p == 4);
			// the first phase runs small grants only, past a full used table
			for (int n = 0; n < (p == 0 ? 80 : 54); n++) begin
				if ($urandom_range(0, 99) < alloc_pct[p]) begin
					if (p == 0)
						req = $urandom_range(0, 256);
					else
						case ($urandom_range(0, 9))
							0:       req = $urandom_range(0, 65536);
							1, 2:    req = $urandom_range(0, arena);
							default: req = $urandom_range(0, 256);
						endcase
					request(FUNC_ALLOC, req, $urandom_range(0, 65535));
				end else begin
					if (used_cnt > 0 && $urandom_range(0, 99) < 80)
						addr = (used_start[$urandom_range(0, used_cnt - 1)] + HEADER_BYTES)
							& 16'hFFFF;
					else
						addr = $urandom_range(0, 65535);
					request(FUNC_FREE, $urandom_range(0, 65536), addr);
				end
			end
			drain();
		end

		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("PASS free_list_fit_allocator");
		else
			$display("FAIL free_list_fit_allocator");
		$finish;
	end

endmodule
